### src/ilir_pkg.sv
// Shared constants, codes and control types of the indexed list unit.
`timescale 1ns / 1ps
`default_nettype none
package ilir_pkg;

	// List capacity and derived widths
	localparam int CAPACITY = 64;
	localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW       = $clog2(CAPACITY + 1);

	// Field widths
	localparam int FUNC_W    = 3;
	localparam int POS_W     = 7;
	localparam int WORD_W    = 32;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 7;

	// Compare width for position against count
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	// Stream packing, first field in the lowest bits
	localparam int FUNC_LSB = 0;
	localparam int POS_LSB  = FUNC_LSB + FUNC_W;
	localparam int WORD_LSB = POS_LSB + POS_W;
	localparam int IN_BITS  = FUNC_W + POS_W + WORD_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STAT_W + WORD_W + CNT_OUT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [FUNC_W-1:0] {
		OP_APPEND = 3'd0,
		OP_DROP   = 3'd1,
		OP_READ   = 3'd2,
		OP_WRITE  = 3'd3,
		OP_INSERT = 3'd4,
		OP_REMOVE = 3'd5,
		OP_CLEAR  = 3'd6,
		OP_NOP    = 3'd7
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT_UP,
		S_PLACE,
		S_SHIFT_DN,
		S_DONE
	} state_t;

	// Memory write selection
	typedef enum logic [2:0] {
		W_NONE,
		W_TAIL,   // entry at count <- request word
		W_POS,    // entry at position <- request word
		W_UP,     // entry at index + 1 <- read data
		W_DN      // entry at index <- read data
	} wr_t;

	// Memory read selection
	typedef enum logic [2:0] {
		R_NONE,
		R_POS,    // position
		R_LAST,   // count - 1
		R_NEXT,   // position + 1
		R_DEC,    // index - 1
		R_SKIP2   // index + 2
	} rd_t;

	typedef enum logic [2:0] {
		I_HOLD,
		I_LAST,
		I_POS,
		I_DEC,
		I_INC
	} idx_t;

	typedef enum logic [1:0] {
		C_HOLD,
		C_INC,
		C_DEC,
		C_CLR
	} cnt_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    load_req;
		wr_t     wr;
		rd_t     rd;
		idx_t    idx;
		cnt_t    cnt;
		logic    set_status;
		status_t status;
		logic    out_load;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		op_t  func;
		logic pos_lt_cnt;
		logic pos_le_cnt;
		logic pos_at_tail;
		logic full;
		logic empty;
		logic idx_at_pos;
		logic idx_at_end;
		logic out_free;
	} flags_t;

endpackage
`default_nettype wire

### src/ilir_dpath.sv
// Datapath of the indexed list unit: request registers, entry memory, count and result register.
`timescale 1ns / 1ps
`default_nettype none
module ilir_dpath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [ilir_pkg::IN_W-1:0]  s_tdata,
	input  wire ilir_pkg::cmd_t        cmd,
	output ilir_pkg::flags_t           flags,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [ilir_pkg::OUT_W-1:0] m_tdata
);
	import ilir_pkg::*;

	op_t               func_q;
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] word_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	status_t           status_q;
	logic [WORD_W-1:0] mem [CAPACITY];
	logic [WORD_W-1:0] rdata_q;

	logic                 out_valid_q;
	logic [STAT_W-1:0]    out_status_q;
	logic [WORD_W-1:0]    out_value_q;
	logic [CNT_OUT_W-1:0] out_count_q;

	logic [CMPW-1:0]   pos_ext;
	logic [CMPW-1:0]   cnt_ext;
	logic [AW-1:0]     pos_a;
	logic [AW-1:0]     cnt_a;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [WORD_W-1:0] wdata;
	logic              we;
	logic              re;
	logic [WORD_W-1:0] result_value;
	logic              out_free;

	// Capture the request on each accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			func_q <= op_t'(s_tdata[FUNC_LSB +: FUNC_W]);
			pos_q  <= s_tdata[POS_LSB +: POS_W];
			word_q <= s_tdata[WORD_LSB +: WORD_W];
		end
	end

	// Compare position and index against the live count
	assign pos_ext = CMPW'(pos_q);
	assign cnt_ext = CMPW'(count_q);
	assign pos_a   = pos_ext[AW-1:0];
	assign cnt_a   = count_q[AW-1:0];
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		flags.func        = func_q;
		flags.pos_lt_cnt  = pos_ext < cnt_ext;
		flags.pos_le_cnt  = pos_ext <= cnt_ext;
		flags.pos_at_tail = ({1'b0, pos_ext} + (CMPW+1)'(1)) == {1'b0, cnt_ext};
		flags.full        = count_q == CW'(CAPACITY);
		flags.empty       = count_q == '0;
		flags.idx_at_pos  = CMPW'(idx_q) == pos_ext;
		flags.idx_at_end  = ((CW+1)'(idx_q) + (CW+1)'(2)) == (CW+1)'(count_q);
		flags.out_free    = out_free;
	end

	// Select write address and data
	always_comb begin
		we    = 1'b1;
		waddr = cnt_a;
		wdata = word_q;
		case (cmd.wr)
			W_TAIL: begin
				waddr = cnt_a;
				wdata = word_q;
			end
			W_POS: begin
				waddr = pos_a;
				wdata = word_q;
			end
			W_UP: begin
				waddr = idx_q + AW'(1);
				wdata = rdata_q;
			end
			W_DN: begin
				waddr = idx_q;
				wdata = rdata_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Select read address
	always_comb begin
		re    = 1'b1;
		raddr = pos_a;
		case (cmd.rd)
			R_POS:   raddr = pos_a;
			R_LAST:  raddr = cnt_a - AW'(1);
			R_NEXT:  raddr = pos_a + AW'(1);
			R_DEC:   raddr = idx_q - AW'(1);
			R_SKIP2: raddr = idx_q + AW'(2);
			default: re = 1'b0;
		endcase
	end

	// Entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Advance the shift index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			case (cmd.idx)
				I_LAST:  idx_q <= cnt_a - AW'(1);
				I_POS:   idx_q <= pos_a;
				I_DEC:   idx_q <= idx_q - AW'(1);
				I_INC:   idx_q <= idx_q + AW'(1);
				default: idx_q <= idx_q;
			endcase
		end
	end

	// Update the live count and the request status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= ST_OK;
		end else begin
			case (cmd.cnt)
				C_INC:   count_q <= count_q + CW'(1);
				C_DEC:   count_q <= count_q - CW'(1);
				C_CLR:   count_q <= '0;
				default: count_q <= count_q;
			endcase
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
		end
	end

	// Form the read word of the result
	always_comb begin
		result_value = '0;
		if (func_q == OP_READ) begin
			result_value = (status_q == ST_BADPOS) ? '1 : rdata_q;
		end
	end

	// Result register, held until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_value_q  <= result_value;
			out_count_q  <= CNT_OUT_W'(count_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, out_count_q, out_value_q, out_status_q};

	// Count never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("live count above capacity");

	// A shift never reads the entry it writes in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (waddr != raddr))
		else $error("read and write at the same entry");

	// The result register is loaded only when it is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result overwritten before taken");

	// A downward shift stays within the live entries
	a_dn_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr == W_DN) |-> ((CW+1)'(idx_q) + (CW+1)'(1) < (CW+1)'(count_q)))
		else $error("downward shift past the live entries");

endmodule
`default_nettype wire

### src/ilir_ctrl.sv
// Controller state machine of the indexed list unit.
`timescale 1ns / 1ps
`default_nettype none
module ilir_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire ilir_pkg::flags_t flags,
	output ilir_pkg::cmd_t        cmd
);
	import ilir_pkg::*;

	state_t state_q;
	state_t state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				if (flags.func == OP_INSERT && flags.pos_le_cnt && !flags.full &&
				    flags.pos_lt_cnt) begin
					state_d = S_SHIFT_UP;
				end
				if (flags.func == OP_REMOVE && flags.pos_lt_cnt && !flags.pos_at_tail) begin
					state_d = S_SHIFT_DN;
				end
			end
			S_SHIFT_UP: begin
				if (flags.idx_at_pos) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				state_d = S_DONE;
			end
			S_SHIFT_DN: begin
				if (flags.idx_at_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (flags.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		s_tready       = 1'b0;
		cmd.load_req   = 1'b0;
		cmd.wr         = W_NONE;
		cmd.rd         = R_NONE;
		cmd.idx        = I_HOLD;
		cmd.cnt        = C_HOLD;
		cmd.set_status = 1'b0;
		cmd.status     = ST_OK;
		cmd.out_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready     = 1'b1;
				cmd.load_req = s_tvalid;
			end
			S_DECODE: begin
				cmd.set_status = 1'b1;
				case (flags.func)
					OP_APPEND: begin
						if (flags.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.wr  = W_TAIL;
							cmd.cnt = C_INC;
						end
					end
					OP_DROP: begin
						if (!flags.empty) begin
							cmd.cnt = C_DEC;
						end
					end
					OP_READ: begin
						if (flags.pos_lt_cnt) begin
							cmd.rd = R_POS;
						end else begin
							cmd.status = ST_BADPOS;
						end
					end
					OP_WRITE: begin
						if (flags.pos_lt_cnt) begin
							cmd.wr = W_POS;
						end else begin
							cmd.status = ST_BADPOS;
						end
					end
					OP_INSERT: begin
						if (!flags.pos_le_cnt) begin
							cmd.status = ST_BADPOS;
						end else if (flags.full) begin
							cmd.status = ST_FULL;
						end else if (!flags.pos_lt_cnt) begin
							// insert at the end appends
							cmd.wr  = W_POS;
							cmd.cnt = C_INC;
						end else begin
							cmd.rd  = R_LAST;
							cmd.idx = I_LAST;
						end
					end
					OP_REMOVE: begin
						if (!flags.pos_lt_cnt) begin
							cmd.status = ST_BADPOS;
						end else if (flags.pos_at_tail) begin
							cmd.cnt = C_DEC;
						end else begin
							cmd.rd  = R_NEXT;
							cmd.idx = I_POS;
						end
					end
					OP_CLEAR: begin
						cmd.cnt = C_CLR;
					end
					default: begin
						cmd.status = ST_OK;
					end
				endcase
			end
			S_SHIFT_UP: begin
				cmd.wr = W_UP;
				if (!flags.idx_at_pos) begin
					cmd.rd  = R_DEC;
					cmd.idx = I_DEC;
				end
			end
			S_PLACE: begin
				cmd.wr  = W_POS;
				cmd.cnt = C_INC;
			end
			S_SHIFT_DN: begin
				cmd.wr = W_DN;
				if (flags.idx_at_end) begin
					cmd.cnt = C_DEC;
				end else begin
					cmd.rd  = R_SKIP2;
					cmd.idx = I_INC;
				end
			end
			S_DONE: begin
				cmd.out_load = flags.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

### src/indexed_list_insert_remove_unit.sv
// Top level of the indexed list unit: controller and datapath.
//
//  channel  | dir | tdata fields (lowest bit up)                 | width
//  ---------+-----+----------------------------------------------+------
//  s_*      | in  | func[2:0], position[9:3], write_value[41:10] | 48
//  m_*      | out | status[1:0], read_value[33:2], count[40:34]  | 48
//
// One request at a time. Append, drop last, read, write, clear, insert at the
// end, removal of the last entry and bad requests go from decode straight to
// the result; insert at position p below count n passes through the shift-up
// and place states and any other remove through the shift-down state, one entry
// moved per cycle through the entry memory's write port and registered read port.
// Reset clears the count and all control state; entry contents stay undefined.
// A pending result waits in its register while the next request is accepted;
// the controller stalls at the end of that request until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module indexed_list_insert_remove_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [ilir_pkg::IN_W-1:0]  s_tdata,  // func, position, write_value
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [ilir_pkg::OUT_W-1:0]      m_tdata   // status, read_value, count
);
	import ilir_pkg::*;

	cmd_t   cmd;
	flags_t flags;

	ilir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.flags    (flags),
		.cmd      (cmd)
	);

	ilir_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.flags    (flags),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

### tb/indexed_list_insert_remove_unit_test.sv
// Self-checking stream testbench for the indexed list unit, with a list predictor.
`timescale 1ns / 1ps
module indexed_list_insert_remove_unit_test;
	import ilir_pkg::*;

	localparam int RD_LSB    = STAT_W;
	localparam int CNT_LSB   = STAT_W + WORD_W;
	localparam int MAX_POS   = (1 << POS_W) - 1;
	localparam int RUN_ITEMS = 440;
	localparam int HOLD_AT   = 200;
	localparam int HOLD_LEN  = 200;
	localparam int TAIL_WAIT = 100;
	localparam int LIMIT     = 400000;

	typedef struct {
		op_t               func;
		logic [POS_W-1:0]  position;
		logic [WORD_W-1:0] write_value;
		int                gap;
		bit                drain;
	} list_request_t;

	typedef struct {
		status_t           status;
		logic [WORD_W-1:0] read_value;
		logic [CNT_OUT_W-1:0] count;
	} list_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	// Stimulus and expected replies
	list_request_t pending_requests[$];
	list_reply_t   expected_replies[$];

	// Predicted list contents
	logic [WORD_W-1:0] list_words[CAPACITY];
	int list_len = 0;

	// Length tracked while building stimulus, used to aim positions
	int gen_len = 0;
	int gen_count = 0;
	bit tx_steady = 1'b0;

	int n_sent = 0;
	int n_done = 0;
	int mismatches = 0;
	int cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int op_seen[8];
	int n_badpos = 0;
	int n_full = 0;

	// Driver and monitor private state
	logic drv_acc;
	int gap_left = 0;
	int cur_gap = 0;
	list_request_t drv_next;
	int stall_left = 0;
	list_reply_t mon_want;
	logic [STAT_W-1:0] got_status;
	logic [WORD_W-1:0] got_read;
	logic [CNT_OUT_W-1:0] got_count;

	indexed_list_insert_remove_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // func, position, write_value
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // status, read_value, count
	);

	always #5 clk = ~clk;

	// Apply one request to the predicted list and return its reply
	function automatic list_reply_t apply_request(op_t f, logic [POS_W-1:0] p,
			logic [WORD_W-1:0] w);
		list_reply_t r;
		int pi;
		int i;
		pi = p;
		r.status = ST_OK;
		r.read_value = '0;
		case (f)
			OP_APPEND: begin
				if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					list_words[list_len] = w;
					list_len++;
				end
			end
			OP_DROP: begin
				if (list_len > 0)
					list_len--;
			end
			OP_READ: begin
				if (pi < list_len) begin
					r.read_value = list_words[pi];
				end else begin
					r.status = ST_BADPOS;
					r.read_value = '1;
				end
			end
			OP_WRITE: begin
				if (pi < list_len)
					list_words[pi] = w;
				else
					r.status = ST_BADPOS;
			end
			OP_INSERT: begin
				if (pi > list_len) begin
					r.status = ST_BADPOS;
				end else if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (i = list_len; i > pi; i--)
						list_words[i] = list_words[i-1];
					list_words[pi] = w;
					list_len++;
				end
			end
			OP_REMOVE: begin
				if (pi >= list_len) begin
					r.status = ST_BADPOS;
				end else begin
					for (i = pi; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			OP_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		r.count = list_len[CNT_OUT_W-1:0];
		return r;
	endfunction

	// Queue one request and track the list length it leaves behind
	task automatic add_request(op_t f, int p, logic [WORD_W-1:0] w, bit drain = 1'b0);
		list_request_t q;
		q.func = f;
		q.position = p[POS_W-1:0];
		q.write_value = w;
		q.gap = tx_steady ? 0 : $urandom_range(0, 7);
		q.drain = drain;
		pending_requests.insert(pending_requests.size(), q);
		gen_count++;
		case (f)
			OP_APPEND: if (gen_len < CAPACITY) gen_len++;
			OP_DROP:   if (gen_len > 0) gen_len--;
			OP_INSERT: if (p <= gen_len && gen_len < CAPACITY) gen_len++;
			OP_REMOVE: if (p < gen_len) gen_len--;
			OP_CLEAR:  gen_len = 0;
			default: begin
			end
		endcase
	endtask

	// Mostly positions near the live range, sometimes anywhere
	function automatic int pick_position();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, MAX_POS);
		return $urandom_range(0, gen_len);
	endfunction

	// One request from a weighted mix of all operations
	task automatic add_mixed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 18)
			add_request(OP_APPEND, pick_position(), $urandom);
		else if (r < 28)
			add_request(OP_DROP, pick_position(), $urandom);
		else if (r < 46)
			add_request(OP_READ, pick_position(), $urandom);
		else if (r < 60)
			add_request(OP_WRITE, pick_position(), $urandom);
		else if (r < 75)
			add_request(OP_INSERT, pick_position(), $urandom);
		else if (r < 90)
			add_request(OP_REMOVE, pick_position(), $urandom);
		else if (r < 93)
			add_request(OP_CLEAR, pick_position(), $urandom);
		else
			add_request(OP_NOP, pick_position(), $urandom);
	endtask

	// Present requests, predict each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			drv_acc = s_tvalid && s_tready;
			if (drv_acc) begin
				expected_replies.insert(expected_replies.size(), apply_request(
					op_t'(s_tdata[FUNC_LSB +: FUNC_W]),
					s_tdata[POS_LSB +: POS_W],
					s_tdata[WORD_LSB +: WORD_W]));
				op_seen[s_tdata[FUNC_LSB +: FUNC_W]]++;
				n_sent <= n_sent + 1;
				gap_left = cur_gap;
			end
			if (!s_tvalid || drv_acc) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() != 0 &&
						!(pending_requests[0].drain && (n_sent + drv_acc != n_done))) begin
					drv_next = pending_requests.pop_front();
					cur_gap = drv_next.gap;
					s_tvalid <= 1'b1;
					s_tdata <= {{(IN_W-IN_BITS){1'b0}}, drv_next.write_value,
						drv_next.position, drv_next.func};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Hold the result side off once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_sent == HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end
	end

	// Report one mismatch and count it
	task automatic report_mismatch(string msg);
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	// Take results and compare each with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_done <= n_done + 1;
				got_status = m_tdata[0 +: STAT_W];
				got_read = m_tdata[RD_LSB +: WORD_W];
				got_count = m_tdata[CNT_LSB +: CNT_OUT_W];
				if (expected_replies.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					mon_want = expected_replies.pop_front();
					if (got_status != mon_want.status)
						report_mismatch($sformatf("result %0d status %0d, expected %0d",
							n_done, got_status, mon_want.status));
					if (got_read != mon_want.read_value)
						report_mismatch($sformatf("result %0d read_value %h, expected %h",
							n_done, got_read, mon_want.read_value));
					if (got_count != mon_want.count)
						report_mismatch($sformatf("result %0d count %0d, expected %0d",
							n_done, got_count, mon_want.count));
					if (mon_want.status == ST_BADPOS)
						n_badpos++;
					if (mon_want.status == ST_FULL)
						n_full++;
				end
				stall_left = ((n_done / 50) % 3 == 2) ? 0 : $urandom_range(0, 7);
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int kind;
		int k;
		int target;
		bit first;

		// Directed: empty list, edges of the fields, every operation
		add_request(OP_READ, 0, 32'h0000_0000);
		add_request(OP_DROP, 0, 32'h0000_0000);
		add_request(OP_WRITE, 0, 32'hFFFF_FFFF);
		add_request(OP_REMOVE, 0, 32'h0000_0000);
		add_request(OP_INSERT, 1, 32'h1234_5678);
		add_request(OP_NOP, MAX_POS, 32'hFFFF_FFFF);
		add_request(OP_INSERT, 0, 32'h8000_0000);
		add_request(OP_APPEND, MAX_POS, 32'h7FFF_FFFF);
		add_request(OP_APPEND, 0, 32'hFFFF_FFFF);
		add_request(OP_INSERT, 1, 32'h0000_0000);
		add_request(OP_INSERT, 4, 32'h0000_0001);
		for (k = 0; k < 5; k++)
			add_request(OP_READ, k, 32'h0);
		add_request(OP_READ, 5, 32'h0);
		add_request(OP_WRITE, 2, 32'h5555_5555);
		add_request(OP_READ, 2, 32'hAAAA_AAAA);
		add_request(OP_REMOVE, 0, 32'h0);
		add_request(OP_REMOVE, 3, 32'h0);
		add_request(OP_READ, MAX_POS, 32'h0);
		add_request(OP_DROP, 0, 32'h0);
		add_request(OP_CLEAR, 0, 32'h0);
		add_request(OP_READ, 0, 32'h0);

		// Random sequences: fills to capacity, mixed traffic, shrinks
		first = 1'b1;
		while (gen_count < RUN_ITEMS) begin
			kind = first ? 0 : $urandom_range(0, 9);
			first = 1'b0;
			tx_steady = ($urandom_range(0, 2) == 0);
			if (kind < 2) begin
				// Fill after the pipe drains, then poke the full list
				add_request(OP_APPEND, pick_position(), $urandom, 1'b1);
				while (gen_len < CAPACITY) begin
					if ($urandom_range(0, 1) == 0)
						add_request(OP_APPEND, pick_position(), $urandom);
					else
						add_request(OP_INSERT, $urandom_range(0, gen_len), $urandom);
				end
				add_request(OP_APPEND, pick_position(), $urandom);
				add_request(OP_INSERT, $urandom_range(0, CAPACITY), $urandom);
				add_request(OP_INSERT, $urandom_range(CAPACITY + 1, MAX_POS), $urandom);
				add_request(OP_READ, $urandom_range(0, CAPACITY - 1), $urandom);
				add_request(OP_REMOVE, $urandom_range(0, CAPACITY - 1), $urandom);
			end else if (kind < 8) begin
				for (k = 0; k < 20; k++)
					add_mixed();
			end else begin
				target = $urandom_range(0, 4);
				while (gen_len > target) begin
					if ($urandom_range(0, 2) == 0)
						add_request(OP_DROP, pick_position(), $urandom);
					else
						add_request(OP_REMOVE, $urandom_range(0, gen_len - 1), $urandom);
				end
				if ($urandom_range(0, 1) == 0)
					add_request(OP_CLEAR, pick_position(), $urandom);
			end
		end

		// Release reset
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go in and every result to come back
		@(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || n_sent != n_done)
			@(negedge clk);
		repeat (TAIL_WAIT) @(negedge clk);
		if (expected_replies.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));

		$display("Covered %0d requests (%0d inserts, %0d removes, %0d reads), %0d results",
			n_sent, op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_READ], n_done);
		$display("Replies with bad position: %0d, with list full: %0d", n_badpos, n_full);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
